/* rtl/fwke_pkg.sv */
// ----------------------------------------------------------------------------
// fwke_pkg
// Shared sizes, codes and controller/datapath interface types for the
// queue with keyed extract.
// ----------------------------------------------------------------------------
`default_nettype none

package fwke_pkg;

    localparam int DEPTH        = 16;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int SLOT_BITS    = $clog2(DEPTH);
    localparam int CNT_BITS     = $clog2(DEPTH + 1);
    localparam int KIND_BITS    = 2;
    localparam int STATUS_BITS  = 2;
    localparam int ENTRY_BITS   = KEY_BITS + PAYLOAD_BITS;
    localparam int S_DATA_BITS  = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS  = ((KEY_BITS + PAYLOAD_BITS + CNT_BITS + 7) / 8) * 8;

    localparam logic [KIND_BITS-1:0] KIND_ENQ     = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DEQ     = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_EXTRACT = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RETURNED = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NONE     = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic load;
        logic rd_first;
        logic step;
        logic enq;
        logic remove;
        logic res_none;
        logic res_full;
    } fwke_cmd_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic                 empty;
        logic                 full;
        logic                 key_hit;
        logic                 last;
        logic                 out_free;
    } fwke_sts_t;

endpackage

`default_nettype wire

/* rtl/fwke_ram.sv */
// ----------------------------------------------------------------------------
// fwke_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fwke_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/fwke_ctrl.sv */
// ----------------------------------------------------------------------------
// fwke_ctrl
// Controller: sequences enqueue, dequeue and the linked extract walk.
// ----------------------------------------------------------------------------
`default_nettype none

module fwke_ctrl import fwke_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire fwke_sts_t sts,
    output fwke_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_DEQ    = 2'd2;
    localparam logic [1:0] S_EXT    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (sts.kind)
                    KIND_ENQ: begin
                        if (sts.out_free) begin
                            cmd.res_full = sts.full;
                            cmd.enq      = !sts.full;
                            state_next   = S_IDLE;
                        end
                    end
                    KIND_DEQ, KIND_EXTRACT: begin
                        if (sts.empty) begin
                            if (sts.out_free) begin
                                cmd.res_none = 1'b1;
                                state_next   = S_IDLE;
                            end
                        end else begin
                            cmd.rd_first = 1'b1;
                            state_next   = (sts.kind == KIND_DEQ) ? S_DEQ : S_EXT;
                        end
                    end
                    default: begin
                        if (sts.out_free) begin
                            cmd.res_none = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end
            S_DEQ: begin
                if (sts.out_free) begin
                    cmd.remove = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EXT: begin
                if (sts.key_hit) begin
                    if (sts.out_free) begin
                        cmd.remove = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (sts.last) begin
                    if (sts.out_free) begin
                        cmd.res_none = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/fwke_dp.sv */
// ----------------------------------------------------------------------------
// fwke_dp
// Datapath: slot RAMs, link chain pointers, used bits and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fwke_dp import fwke_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [S_DATA_BITS-1:0] s_tdata,
    input  wire logic [KIND_BITS-1:0]   s_tuser,
    input  wire logic                   m_tready,
    input  wire fwke_cmd_t              cmd,
    output fwke_sts_t                   sts,
    output logic                        m_tvalid,
    output logic [M_DATA_BITS-1:0]      m_tdata,
    output logic [STATUS_BITS-1:0]      m_tuser
);

    logic [KIND_BITS-1:0]    kind_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;

    logic [SLOT_BITS-1:0] head_reg, head_next;
    logic [SLOT_BITS-1:0] tail_reg, tail_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [DEPTH-1:0]     used_reg, used_next;
    logic [SLOT_BITS-1:0] cur_reg, cur_next;
    logic [SLOT_BITS-1:0] prev_reg, prev_next;
    logic [SLOT_BITS-1:0] n_reg, n_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0]  status_reg;
    logic [KEY_BITS-1:0]     okey_reg;
    logic [PAYLOAD_BITS-1:0] opay_reg;
    logic [CNT_BITS-1:0]     occ_reg;

    logic [SLOT_BITS-1:0]  free_slot;
    logic [ENTRY_BITS-1:0] entry_rdata;
    logic [SLOT_BITS-1:0]  link_rdata;
    logic                  rd_en;
    logic [SLOT_BITS-1:0]  rd_addr;
    logic                  link_wr_en;
    logic [SLOT_BITS-1:0]  link_wr_addr;
    logic [SLOT_BITS-1:0]  link_wr_data;
    logic                  out_free;
    logic [KEY_BITS-1:0]   rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    assign rd_key   = entry_rdata[KEY_BITS-1:0];
    assign rd_pay   = entry_rdata[ENTRY_BITS-1:KEY_BITS];
    assign out_free = !out_valid_reg || m_tready;

    // lowest-numbered free slot
    always_comb begin
        free_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_slot = SLOT_BITS'(i);
            end
        end
    end

    assign rd_en        = cmd.rd_first || cmd.step;
    assign rd_addr      = cmd.step ? link_rdata : head_reg;
    assign link_wr_en   = (cmd.enq && count_reg != '0) || (cmd.remove && n_reg != '0);
    assign link_wr_addr = cmd.enq ? tail_reg : prev_reg;
    assign link_wr_data = cmd.enq ? free_slot : link_rdata;

    fwke_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (cmd.enq),
        .wr_addr (free_slot),
        .wr_data ({payload_reg, key_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (entry_rdata)
    );

    fwke_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (link_rdata)
    );

    assign sts.kind     = kind_reg;
    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (count_reg == CNT_BITS'(DEPTH));
    assign sts.key_hit  = (rd_key == key_reg);
    assign sts.last     = ({1'b0, n_reg} == CNT_BITS'(count_reg - 1'b1));
    assign sts.out_free = out_free;

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cmd.rd_first) begin
            cur_next  = head_reg;
            prev_next = '0;
            n_next    = '0;
        end
        if (cmd.step) begin
            prev_next = cur_reg;
            cur_next  = link_rdata;
            n_next    = n_reg + 1'b1;
        end
        if (cmd.enq) begin
            used_next[free_slot] = 1'b1;
            if (count_reg == '0) begin
                head_next = free_slot;
            end
            tail_next  = free_slot;
            count_next = count_reg + 1'b1;
        end
        if (cmd.remove) begin
            used_next[cur_reg] = 1'b0;
            count_next         = count_reg - 1'b1;
            if (n_reg == '0) begin
                head_next = link_rdata;
            end else if (cur_reg == tail_reg) begin
                tail_next = prev_reg;
            end
            if (count_reg == CNT_BITS'(1)) begin
                head_next = '0;
                tail_next = '0;
            end
        end
        if (cmd.enq || cmd.remove || cmd.res_none || cmd.res_full) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            used_reg      <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= s_tuser;
            key_reg     <= s_tdata[KEY_BITS-1:0];
            payload_reg <= s_tdata[ENTRY_BITS-1:KEY_BITS];
        end
        if (cmd.enq || cmd.remove || cmd.res_none || cmd.res_full) begin
            occ_reg <= count_next;
            if (cmd.remove) begin
                status_reg <= ST_RETURNED;
                okey_reg   <= rd_key;
                opay_reg   <= rd_pay;
            end else begin
                status_reg <= cmd.enq ? ST_ACCEPTED : (cmd.res_full ? ST_FULL : ST_NONE);
                okey_reg   <= '0;
                opay_reg   <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = M_DATA_BITS'({occ_reg, opay_reg, okey_reg});

endmodule

`default_nettype wire

/* rtl/fifo_with_keyed_extract_core.sv */
// ----------------------------------------------------------------------------
// fifo_with_keyed_extract_core
// Bounded queue of keyed entries with enqueue, dequeue and first-match extract.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                  | tuser
//  s_       | in        | resource_key, entry_payload         | kind
//  m_       | out       | out_key, out_payload, occupancy     | status
//
//  result registered from the decide state for enqueue, unused kinds and an
//  empty queue, after the head read for dequeue; extract compares at most 16
//  entries, one link ram read per cycle walking oldest to newest until a match
//  s_tready returns in the same cycle the result turns valid; one transaction
//  in flight, and a stalled output register holds the next one before its result
//  aresetn clears the queue pointers, count and used bits; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_keyed_extract_core import fwke_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_DATA_BITS-1:0] s_tdata,  // resource_key, entry_payload
    input  wire logic [KIND_BITS-1:0]   s_tuser,  // kind
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_DATA_BITS-1:0]      m_tdata,  // out_key, out_payload, occupancy
    output logic [STATUS_BITS-1:0]      m_tuser   // status
);

    fwke_cmd_t cmd;
    fwke_sts_t sts;

    fwke_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fwke_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("transaction accepted while another is in flight");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.enq, cmd.remove, cmd.res_none, cmd.res_full}))
        else $error("more than one result issued in a cycle");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_RETURNED |->
            m_tdata[ENTRY_BITS-1:0] == '0)
        else $error("key or payload nonzero without a returned entry");

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[ENTRY_BITS+CNT_BITS-1:ENTRY_BITS] <= CNT_BITS'(DEPTH))
        else $error("occupancy beyond depth");

    a_full_enq: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.enq |-> !sts.full)
        else $error("enqueue into a full queue");

endmodule

`default_nettype wire
